// File: rtl/bsc_pkg.sv
// Package for the barometric sensor compensation block: payload structs,
// calibration register indexes and the fixed constants of the compensation.
// Depends on nothing.
`timescale 1ns / 1ps

package bsc_pkg;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [16:0] pressure_pa;
    logic               clipped;
  } result_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CAL_W       = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

endpackage

// File: rtl/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation pipeline, with its
// calibration registers and output skid stage. Depends on bsc_pkg.
`timescale 1ns / 1ps

// Channel   | Handshake                        | Payload
// ----------+----------------------------------+------------------------------
// sample    | sample_valid / sample_stall      | sample_t (raw D1, raw D2)
// result    | result_valid / result_stall      | result_t (temp, pressure, clip)
// cfg       | cfg_valid / cfg_ready            | cfg_index, cfg_data (16 bits)
//
// One sample pair is taken every cycle while sample_stall is low; a result for
// each sample goes through nine compute stages and then the output register.
// The widest step is the 24 x 44 bit pressure product, split into two
// partial products over two stages. rst clears the calibration words and
// all valid bits. A stalled result is held in the output register; the next
// one lands in a skid register, and sample_stall rises only while that is full.

module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]       cfg_data
);

  localparam int STAGES = 9;

  logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6;

  logic [STAGES-1:0] vld;
  logic              skid_v;
  result_t           skid_d;
  logic              en;

  // Stage registers.
  logic signed [24:0] dt1;
  logic        [23:0] d1_1, d1_2, d1_3, d1_4, d1_5, d1_6;
  logic signed [41:0] m6, m4, m3;
  logic signed [49:0] mdd;
  logic signed [18:0] e3;
  logic signed [19:0] temp3;
  logic signed [20:0] g3;
  logic signed [35:0] off3, off4, off5;
  logic signed [34:0] sens3, sens4, sens5;
  logic        [17:0] t2_3;
  logic               low3, vlow3;
  logic        [36:0] a4;
  logic        [37:0] b4;
  logic signed [20:0] temp4;
  logic        [41:0] off2_5, sens2_5;
  logic signed [14:0] tout5, tout6, tout7, tout8, tout9;
  logic               tclip5, tclip6, tclip7, tclip8, tclip9;
  logic signed [43:0] offc6, offc7, offc8;
  logic signed [43:0] sensc6;
  logic        [45:0] pl7;
  logic signed [46:0] ph7;
  logic signed [68:0] prod8;
  logic signed [32:0] p9;

  // Combinational values between stages.
  logic signed [18:0] e_c;
  logic signed [19:0] temp_c;
  logic signed [20:0] g_c;
  logic signed [34:0] m4s;
  logic signed [33:0] m3s;
  logic signed [35:0] off_c;
  logic signed [34:0] sens_c;
  logic signed [37:0] sq_a;
  logic signed [41:0] sq_b;
  logic signed [20:0] temp4_c;
  logic        [39:0] five_a;
  logic        [40:0] seven_b;
  logic        [41:0] eleven_b;
  logic signed [47:0] q_c;
  result_t            nd;

  assign cfg_ready    = 1'b1;
  assign en           = !skid_v;
  assign sample_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1:  c1 <= cfg_data;
        REG_C2:  c2 <= cfg_data;
        REG_C3:  c3 <= cfg_data;
        REG_C4:  c4 <= cfg_data;
        REG_C5:  c5 <= cfg_data;
        REG_C6:  c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 3 arithmetic: flooring shifts are taken as upper part-selects.
  assign e_c    = m6[41:23];
  assign temp_c = 20'(e_c) + 20'(TEMP_REF);
  assign g_c    = 21'(temp_c) - 21'(TEMP_VLOW);
  assign m4s    = m4[41:7];
  assign m3s    = m3[41:8];
  assign off_c  = $signed({4'd0, c2, 16'd0}) + 36'(m4s);
  assign sens_c = $signed({4'd0, c1, 15'd0}) + 35'(m3s);

  // Stage 4 arithmetic.
  assign sq_a    = e3 * e3;
  assign sq_b    = g3 * g3;
  assign temp4_c = low3 ? (21'(temp3) - $signed({3'd0, t2_3})) : 21'(temp3);

  // Stage 5 arithmetic: small constant multiples as shift and add or subtract.
  assign five_a   = {1'b0, a4, 2'b00} + 40'(a4);
  assign seven_b  = {b4, 3'b000} - 41'(b4);
  assign eleven_b = {1'b0, b4, 3'b000} + 42'({b4, 1'b0}) + 42'(b4);

  // Stage 9 arithmetic.
  assign q_c = prod8[68:21] - 48'(offc8);

  // Pressure clamp feeding the output and skid registers.
  always_comb begin
    nd.temperature_centi = tout9;
    nd.clipped           = tclip9;
    if (p9 < 33'(PRES_MIN)) begin
      nd.pressure_pa = 17'(PRES_MIN);
      nd.clipped     = 1'b1;
    end else if (p9 > 33'(PRES_MAX)) begin
      nd.pressure_pa = 17'(PRES_MAX);
      nd.clipped     = 1'b1;
    end else begin
      nd.pressure_pa = p9[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], sample_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: temperature difference.
      dt1  <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5, 8'd0});
      d1_1 <= sample.raw_pressure;

      // Stage 2: the four products of dT.
      m6   <= dt1 * $signed({1'b0, c6});
      m4   <= dt1 * $signed({1'b0, c4});
      m3   <= dt1 * $signed({1'b0, c3});
      mdd  <= dt1 * dt1;
      d1_2 <= d1_1;

      // Stage 3: first-order temperature, offset and sensitivity.
      e3    <= e_c;
      temp3 <= temp_c;
      g3    <= g_c;
      off3  <= off_c;
      sens3 <= sens_c;
      t2_3  <= mdd[48:31];
      low3  <= e_c[18];
      vlow3 <= g_c[20];
      d1_3  <= d1_2;

      // Stage 4: squares for the low-temperature corrections.
      a4    <= low3 ? sq_a[36:0] : '0;
      b4    <= vlow3 ? sq_b[37:0] : '0;
      temp4 <= temp4_c;
      off4  <= off3;
      sens4 <= sens3;
      d1_4  <= d1_3;

      // Stage 5: second-order terms and temperature clamp.
      off2_5  <= 42'(five_a[39:1]) + 42'(seven_b);
      sens2_5 <= 42'(five_a[39:2]) + 42'(eleven_b[41:1]);
      off5    <= off4;
      sens5   <= sens4;
      d1_5    <= d1_4;
      if (temp4 < 21'(TEMP_MIN)) begin
        tout5  <= 15'(TEMP_MIN);
        tclip5 <= 1'b1;
      end else if (temp4 > 21'(TEMP_MAX)) begin
        tout5  <= 15'(TEMP_MAX);
        tclip5 <= 1'b1;
      end else begin
        tout5  <= temp4[14:0];
        tclip5 <= 1'b0;
      end

      // Stage 6: corrected offset and sensitivity.
      offc6  <= 44'(off5) - $signed({2'b00, off2_5});
      sensc6 <= 44'(sens5) - $signed({2'b00, sens2_5});
      d1_6   <= d1_5;
      tout6  <= tout5;
      tclip6 <= tclip5;

      // Stage 7: partial products of D1 times the sensitivity.
      pl7    <= d1_6 * sensc6[21:0];
      ph7    <= $signed({1'b0, d1_6}) * $signed(sensc6[43:22]);
      offc7  <= offc6;
      tout7  <= tout6;
      tclip7 <= tclip6;

      // Stage 8: combine the partial products.
      prod8  <= (69'(ph7) <<< 22) + $signed({23'd0, pl7});
      offc8  <= offc7;
      tout8  <= tout7;
      tclip8 <= tclip7;

      // Stage 9: pressure before clamping.
      p9     <= q_c[47:15];
      tout9  <= tout8;
      tclip9 <= tclip8;
    end
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (!result_stall) begin
        result_valid <= 1'b1;
        skid_v       <= 1'b0;
      end
    end else if (result_valid && result_stall) begin
      skid_v <= vld[STAGES-1];
    end else begin
      result_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!result_stall) begin
        result <= skid_d;
      end
    end else if (result_valid && result_stall) begin
      skid_d <= nd;
    end else begin
      result <= nd;
    end
  end

endmodule

// File: sim/baro_sensor_compensation_tb.sv
// Self-checking testbench for baro_sensor_compensation: a directed table, then fixed
// and random calibration phases checked against an integer model of the second-order
// compensation. Depends on bsc_pkg and the RTL top level.
`timescale 1ns / 1ps

module baro_sensor_compensation_tb;
  import bsc_pkg::*;

  localparam int NUM_CAL         = int'(REG_C6) + 1;
  localparam int SETTLE_CYCLES   = 14;
  localparam int HOLD_CYCLES     = 150;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 128;
  localparam longint CYCLE_LIMIT = 200000;

  // Indexes past the last calibration word; writes there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  // Datasheet-style calibration set, C1 at index 0.
  localparam logic [5:0][15:0] TYPICAL_CAL = {16'd28312, 16'd33464, 16'd23282,
                                              16'd23317, 16'd36924, 16'd40127};

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CAL_W-1:0]       data;
    sample_t                smp;
    logic                   typed;
    result_t                want;
  } vector_t;

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  sample_t                sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CAL_W-1:0]       cfg_data     = '0;

  logic [CAL_W-1:0] cal_word [NUM_CAL];
  result_t          pending_results [$];
  result_t          oldest;
  vector_t          dir_table [$];
  int               error_count = 0;
  int               burst_left  = 0;
  longint           cycle_count = 0;

  int               hold_req  = 0;
  int               hold_ack  = 0;
  int               hold_left = 0;
  int               mode_left = 0;
  stall_mode_t      stall_mode = STALL_NONE;

  baro_sensor_compensation u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Integer compensation with the current calibration words. All shifts are
  // arithmetic on 64-bit signed values, so they floor. The net offset and
  // sensitivity are handed back so the stimulus can aim at a pressure.
  function automatic result_t compensate(input sample_t s, output longint net_off,
                                         output longint net_sens);
    longint  d1, d2, c1, c2, c3, c4, c5, c6;
    longint  dt, temp, off, sens, t2, off2, sens2, dev_lo, dev_vlo, p;
    logic    clip;
    result_t r;
    d1 = s.raw_pressure;
    d2 = s.raw_temperature;
    c1 = cal_word[REG_C1];
    c2 = cal_word[REG_C2];
    c3 = cal_word[REG_C3];
    c4 = cal_word[REG_C4];
    c5 = cal_word[REG_C5];
    c6 = cal_word[REG_C6];
    dt   = d2 - c5 * 256;
    temp = TEMP_REF + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < TEMP_REF) begin
      dev_lo = (temp - TEMP_REF) * (temp - TEMP_REF);
      t2     = (dt * dt) >>> 31;
      off2   = (5 * dev_lo) >>> 1;       // 2.5 x
      sens2  = (5 * dev_lo) >>> 2;       // 1.25 x
      if (temp < TEMP_VLOW) begin
        dev_vlo = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
        off2    = off2 + 7 * dev_vlo;
        sens2   = sens2 + ((11 * dev_vlo) >>> 1);   // 5.5 x
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    net_off  = off;
    net_sens = sens;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    clip = 1'b0;
    if (temp < TEMP_MIN) begin
      temp = TEMP_MIN;
      clip = 1'b1;
    end
    if (temp > TEMP_MAX) begin
      temp = TEMP_MAX;
      clip = 1'b1;
    end
    if (p < PRES_MIN) begin
      p    = PRES_MIN;
      clip = 1'b1;
    end
    if (p > PRES_MAX) begin
      p    = PRES_MAX;
      clip = 1'b1;
    end
    r.temperature_centi = temp[14:0];
    r.pressure_pa       = p[16:0];
    r.clipped           = clip;
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Result checker: every accepted transaction is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        note_error("result transaction with nothing expected");
      end else begin
        oldest = pending_results.pop_front();
        if (result.temperature_centi !== oldest.temperature_centi)
          note_error($sformatf("temperature_centi got %0d want %0d",
                               result.temperature_centi, oldest.temperature_centi));
        if (result.pressure_pa !== oldest.pressure_pa)
          note_error($sformatf("pressure_pa got %0d want %0d",
                               result.pressure_pa, oldest.pressure_pa));
        if (result.clipped !== oldest.clipped)
          note_error($sformatf("clipped got %0b want %0b", result.clipped, oldest.clipped));
      end
    end
  end

  // Receiver: changes its stall pattern whenever its random mode counter runs out, and
  // on request holds off steadily so the pipeline backs up into sample_stall.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
        default:     result_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CAL_W-1:0] val);
    vector_t v;
    v          = '0;
    v.is_write = 1'b1;
    v.index    = idx;
    v.data     = val;
    dir_table.push_back(v);
  endtask

  task automatic add_sample(input logic [23:0] d1, input logic [23:0] d2);
    vector_t v;
    v                     = '0;
    v.smp.raw_pressure    = d1;
    v.smp.raw_temperature = d2;
    dir_table.push_back(v);
  endtask

  // With every calibration word at zero the temperature sits at the reference
  // and the pressure is zero, so it is clamped up and flagged.
  task automatic add_typed(input logic [23:0] d1, input logic [23:0] d2);
    vector_t v;
    v                        = '0;
    v.smp.raw_pressure       = d1;
    v.smp.raw_temperature    = d2;
    v.typed                  = 1'b1;
    v.want.temperature_centi = 15'(TEMP_REF);
    v.want.pressure_pa       = 17'(PRES_MIN);
    v.want.clipped           = 1'b1;
    dir_table.push_back(v);
  endtask

  task automatic write_cal(input logic [CFG_INDEX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_CAL) cal_word[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Leaves sample_valid high on return; the caller either offers the next
  // sample in the same step or lowers it.
  task automatic send_sample(input sample_t s, input logic typed, input result_t want);
    longint off_unused, sens_unused;
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(compensate(s, off_unused, sens_unused));
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int      phase, n, k, tgt_temp, tgt_pres;
    longint  dt, d1, d2, num, off_est, sens_est;
    sample_t s;
    result_t probe;
    logic [CAL_W-1:0] val;

    foreach (cal_word[k]) cal_word[k] = '0;

    // Reset values first, then writes to the spare indexes that must not land.
    add_typed(24'h000000, 24'h000000);
    add_typed(24'hFFFFFF, 24'hFFFFFF);
    add_typed(24'h000000, 24'hFFFFFF);
    add_typed(24'hFFFFFF, 24'h000000);
    add_write(REG_SPARE_A, 16'hFFFF);
    add_write(REG_SPARE_B, 16'hFFFF);
    add_typed(24'h800000, 24'h800000);
    for (k = 0; k < NUM_CAL; k++) add_write(CFG_INDEX_W'(k), TYPICAL_CAL[k]);
    add_sample(24'd9085466, 24'd8569150);   // near room temperature
    add_sample(24'd9085466, 24'd8000000);   // below 20 degrees
    add_sample(24'd9085466, 24'd7300000);   // below -15 degrees
    add_sample(24'd9085466, 24'd7085303);   // very cold, lands just under the floor
    add_sample(24'd0,       24'd8569150);   // pressure clamps low
    add_sample(24'hFFFFFF,  24'd8569150);   // pressure clamps high
    add_sample(24'd9085466, 24'h000000);    // temperature clamps low
    add_sample(24'd9085466, 24'hFFFFFF);    // temperature clamps high
    add_sample(24'h5A5A5A,  24'hA5A5A5);
    for (k = 0; k < NUM_CAL; k++) add_write(CFG_INDEX_W'(k), 16'hFFFF);
    add_sample(24'h000000, 24'h000000);
    add_sample(24'hFFFFFF, 24'hFFFFFF);
    add_sample(24'hA5A5A5, 24'h5A5A5A);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[k]) begin
      if (dir_table[k].is_write) begin
        wait_drained();
        write_cal(dir_table[k].index, dir_table[k].data);
      end else begin
        send_sample(dir_table[k].smp, dir_table[k].typed, dir_table[k].want);
        pace();
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      for (k = 0; k < NUM_CAL; k++) begin
        case (phase)
          0:       val = TYPICAL_CAL[k];
          1:       val = 16'hFFFF;
          2:       val = 16'h0000;
          default: begin
            case ($urandom_range(0, 7))
              0:       val = 16'h0000;
              1:       val = 16'hFFFF;
              default: val = 16'($urandom());
            endcase
          end
        endcase
        write_cal(CFG_INDEX_W'(k), val);
      end
      if (phase > 2) write_cal($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                               16'($urandom()));

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 40) hold_req <= hold_req + 1;
        if ($urandom_range(0, 9) < 7 && cal_word[REG_C6] != 0) begin
          // Aim at a temperature around the correction thresholds, then pick
          // D1 for a pressure around the valid range.
          tgt_temp = int'($urandom_range(0, 16000)) - 6000;
          dt = longint'(tgt_temp - TEMP_REF) * 64'sd8388608 / longint'(cal_word[REG_C6]);
          d2 = longint'(cal_word[REG_C5]) * 256 + dt;
          if (d2 < 0) d2 = 0;
          if (d2 > 64'sh0FFFFFF) d2 = 64'sh0FFFFFF;
          s.raw_temperature = d2[23:0];
          s.raw_pressure    = '0;
          probe = compensate(s, off_est, sens_est);
          if (sens_est > 0) begin
            tgt_pres = $urandom_range(500, 125000);
            num = (longint'(tgt_pres) * 32768 + off_est) * 2097152;
            d1  = num / sens_est;
            if (d1 < 0) d1 = 0;
            if (d1 > 64'sh0FFFFFF) d1 = 64'sh0FFFFFF;
            s.raw_pressure = d1[23:0];
          end else begin
            s.raw_pressure = 24'($urandom());
          end
        end else begin
          s.raw_pressure    = 24'($urandom());
          s.raw_temperature = 24'($urandom());
        end
        send_sample(s, 1'b0, '0);
        pace();
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bsc_pkg.sv
rtl/baro_sensor_compensation.sv
sim/baro_sensor_compensation_tb.sv
